// File: rtl/bounded_list_store_top_macros.svh
// ----------------------------------------------------------------------------
// Bounded list store assertion macros
// Shared concurrent assertion forms for the list store RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_STORE_TOP_MACROS_SVH
`define BOUNDED_LIST_STORE_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define BLS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) expr) else $error(msg);

`define BLS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define BLS_ASSERT(lbl, expr, msg)

`define BLS_NEVER(lbl, expr, msg)

`endif

`endif

// File: rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// Bounded list store package
// Sizes, operation and status codes, and shared types of the list store.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int CAPACITY     = 32;
  localparam int RESULT_LIMIT = 32;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CMP_W-1:0] RES_LIM = CMP_W'(RESULT_LIMIT);

  localparam logic [2:0] M_APPEND  = 3'd0;
  localparam logic [2:0] M_HEAD    = 3'd1;
  localparam logic [2:0] M_INSERT  = 3'd2;
  localparam logic [2:0] M_REMOVE  = 3'd3;
  localparam logic [2:0] M_REVERSE = 3'd4;
  localparam logic [2:0] M_DUMP    = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  localparam logic [1:0] CMD_HOLD = 2'd0;
  localparam logic [1:0] CMD_INS  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;
  localparam logic [1:0] CMD_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] pos;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] element;
    logic        element_valid;
    logic        last;
  } res_t;

endpackage

// File: rtl/bounded_list_store_top.sv
// Status results are written into the result queue in the cycle the item is accepted.
// Insert, append, head insert and head removal update the cell row without leaving idle.
// Reverse and dump rotate the cell row, one rotation per cycle while a dump
// is not stalled by a full result queue; dump emits the head at each rotation.
// Reset clears the element count, the control state and the result queue;
// element contents are not cleared.
// ----------------------------------------------------------------------------
// Bounded list store
// Ordered list of signed values kept in a row of cells, with insert, remove,
// reverse and dump operations and a two-entry result queue.
// ----------------------------------------------------------------------------
`include "bounded_list_store_top_macros.svh"

module bounded_list_store_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic [5:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] element,
  output logic               element_valid,
  output logic               last
);
  import bls_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REV  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] rp, rp_next;
  logic [CNT_W-1:0] dcnt, dcnt_next;

  res_t fifo [2];
  logic wptr, rptr;
  logic [1:0] fcnt;
  logic push, pop, space;
  res_t push_res;

  cell_ctl_t   ctl;
  logic [31:0] bcast;
  logic [31:0] cell_data [CAPACITY];
  logic [31:0] left_in [CAPACITY];
  logic [31:0] right_in [CAPACITY];
  logic [31:0] head;

  logic             accept;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] last_idx;
  logic [CMP_W-1:0] count_ext, ins_pos_ext, dcnt_ext, lim_ext;
  logic             emit, advance;

  assign head      = cell_data[0];
  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE) && (fcnt != 2'd2);
  assign pop       = out_valid && out_ready;
  assign space     = (fcnt != 2'd2) || pop;
  assign cnt_m1    = count - CNT_W'(1);
  assign last_idx  = cnt_m1[IDX_W-1:0];
  assign count_ext = CMP_W'(count);
  assign dcnt_ext  = CMP_W'(dcnt);
  assign lim_ext   = (count_ext > RES_LIM) ? RES_LIM : count_ext;
  assign emit      = dcnt_ext < RES_LIM;
  assign advance   = !emit || space;

  always_comb begin
    case (mode) inside
      M_APPEND: ins_pos_ext = count_ext;
      M_HEAD:   ins_pos_ext = '0;
      default:  ins_pos_ext = CMP_W'(position);
    endcase
  end

  always_comb begin
    ctl        = '{cmd: CMD_HOLD, pos: '0};
    bcast      = head;
    push       = 1'b0;
    push_res   = '{status: ST_OK, element: '0, element_valid: 1'b0, last: 1'b1};
    count_next = count;
    state_next = state;
    rp_next    = rp;
    dcnt_next  = dcnt;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          push = 1'b1;
          case (mode) inside
            M_APPEND, M_HEAD, M_INSERT: begin
              if (ins_pos_ext > count_ext) begin
                push_res.status = ST_BADPOS;
              end else if (count == CAP_CNT) begin
                push_res.status = ST_FULL;
              end else begin
                ctl        = '{cmd: CMD_INS, pos: ins_pos_ext[IDX_W-1:0]};
                bcast      = value;
                count_next = count + CNT_W'(1);
              end
            end
            M_REMOVE: begin
              if (count == '0) begin
                push_res.status = ST_EMPTY;
              end else begin
                ctl        = '{cmd: CMD_DEL, pos: '0};
                count_next = cnt_m1;
              end
            end
            M_REVERSE: begin
              if (count > CNT_W'(1)) begin
                state_next = S_REV;
                rp_next    = last_idx;
              end
            end
            M_DUMP: begin
              if (count == '0) begin
                push_res.status = ST_EMPTY;
              end else begin
                push       = 1'b0;
                state_next = S_DUMP;
                dcnt_next  = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_REV: begin
        ctl = '{cmd: CMD_ROT, pos: rp};
        if (rp == IDX_W'(1)) begin
          state_next = S_IDLE;
        end else begin
          rp_next = rp - IDX_W'(1);
        end
      end
      S_DUMP: begin
        if (advance) begin
          ctl = '{cmd: CMD_ROT, pos: last_idx};
          if (emit) begin
            push     = 1'b1;
            push_res = '{status: ST_OK, element: head, element_valid: 1'b1,
                         last: (dcnt_ext + CMP_W'(1)) == lim_ext};
          end
          if (dcnt == cnt_m1) begin
            state_next = S_IDLE;
          end else begin
            dcnt_next = dcnt + CNT_W'(1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i] = cell_data[i];
    end else begin : g_mid_l
      assign left_in[i] = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in[i] = cell_data[i];
    end else begin : g_mid_r
      assign right_in[i] = cell_data[i+1];
    end
    bls_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctl        (ctl),
      .left_data  (left_in[i]),
      .right_data (right_in[i]),
      .bcast      (bcast),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      fcnt  <= '0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   fcnt <= fcnt + 2'd1;
        2'b01:   fcnt <= fcnt - 2'd1;
        default: fcnt <= fcnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rp   <= rp_next;
    dcnt <= dcnt_next;
    if (push) begin
      fifo[wptr] <= push_res;
    end
  end

  assign out_valid     = fcnt != 2'd0;
  assign status        = fifo[rptr].status;
  assign element       = fifo[rptr].element;
  assign element_valid = fifo[rptr].element_valid;
  assign last          = fifo[rptr].last;

  `BLS_ASSERT(a_count_cap, count <= CAP_CNT, "Element count exceeds capacity.")
  `BLS_NEVER(a_queue_ovf, push && (fcnt == 2'd2) && !pop, "Result queue overflow.")
  `BLS_ASSERT(a_rev_count, (state == S_REV) |=> $stable(count), "Count changed in reverse.")
  `BLS_ASSERT(a_dump_start, (accept && (mode == M_DUMP) && (count != '0)) |=> (state == S_DUMP), "Dump did not start.")

endmodule

// File: rtl/bls_cell.sv
// ----------------------------------------------------------------------------
// List store cell
// Holds one element and moves it to or from its neighbors on command.
// ----------------------------------------------------------------------------
module bls_cell (
  input  logic                    clk,
  input  logic [bls_pkg::IDX_W-1:0] idx,
  input  bls_pkg::cell_ctl_t      ctl,
  input  logic [31:0]             left_data,
  input  logic [31:0]             right_data,
  input  logic [31:0]             bcast,
  output logic [31:0]             data
);
  import bls_pkg::*;

  logic [31:0] data_next;

  always_comb begin
    data_next = data;
    unique case (ctl.cmd)
      CMD_HOLD: data_next = data;
      CMD_INS: begin
        if (idx > ctl.pos) begin
          data_next = left_data;
        end else if (idx == ctl.pos) begin
          data_next = bcast;
        end
      end
      CMD_DEL: data_next = right_data;
      CMD_ROT: begin
        if (idx < ctl.pos) begin
          data_next = right_data;
        end else if (idx == ctl.pos) begin
          data_next = bcast;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Bounded list store testbench
// Drives list operations through the valid/ready input channel and predicts
// every status and dump result with a queue-based model of the list. Results
// are checked in order against that prediction while both channels idle in
// random bursts. A short directed sequence covers the empty list, the field
// extremes, bad positions and every operation. Random traffic follows, in
// segments that grow, shrink or churn the list so that the full store is hit.
// ----------------------------------------------------------------------------
module testbench;
  import bls_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
  localparam int FLUSH_LIMIT  = 40000;
  localparam int RANDOM_ITEMS = 380;
  localparam int TAIL_ITEMS   = 40;

  localparam logic [2:0] M_SPARE_A = 3'd6;
  localparam logic [2:0] M_SPARE_B = 3'd7;

  typedef enum int {
    BIAS_GROW,
    BIAS_SHRINK,
    BIAS_MIXED
  } traffic_bias_t;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         mode     = M_APPEND;
  logic [5:0]         position = '0;
  logic signed [31:0] value    = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] element;
  logic               element_valid;
  logic               last;

  int   list_model[$];
  res_t expected_results[$];
  res_t oldest_result;
  int   error_count  = 0;
  int   cycle_count  = 0;
  int   item_count   = 0;
  int   result_count = 0;
  int   full_hits    = 0;
  int   mode_count[8];
  bit   quiet        = 1'b0;
  bit   idle_on      = 1'b1;

  bounded_list_store_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .position     (position),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .element      (element),
    .element_valid(element_valid),
    .last         (last)
  );

  always #5 clk = ~clk;

  function automatic res_t make_result(logic [1:0] st, logic [31:0] elem, logic vld,
                                       logic lst);
    res_t r;
    r.status        = st;
    r.element       = elem;
    r.element_valid = vld;
    r.last          = lst;
    return r;
  endfunction

  task automatic predict_list_op(logic [2:0] op, logic [5:0] pos, logic [31:0] val);
    int         reversed[$];
    logic [1:0] st;
    int         at;
    int         n;
    st = ST_OK;
    case (op)
      M_APPEND, M_HEAD, M_INSERT: begin
        at = (op == M_APPEND) ? list_model.size() : (op == M_HEAD) ? 0 : int'(pos);
        if (at > list_model.size()) begin
          st = ST_BADPOS;
        end else if (list_model.size() >= CAPACITY) begin
          st = ST_FULL;
          full_hits++;
        end else begin
          list_model.insert(at, val);
        end
      end
      M_REMOVE: begin
        if (list_model.size() == 0) st = ST_EMPTY;
        else void'(list_model.pop_front());
      end
      M_REVERSE: begin
        foreach (list_model[i]) reversed.push_front(list_model[i]);
        list_model = reversed;
      end
      default: ;
    endcase
    if (op != M_DUMP) begin
      expected_results.push_back(make_result(st, '0, 1'b0, 1'b1));
    end else if (list_model.size() == 0) begin
      expected_results.push_back(make_result(ST_EMPTY, '0, 1'b0, 1'b1));
    end else begin
      n = (list_model.size() > RESULT_LIMIT) ? RESULT_LIMIT : list_model.size();
      for (int i = 0; i < n; i++) begin
        expected_results.push_back(make_result(ST_OK, list_model[i], 1'b1, i == n - 1));
      end
    end
  endtask

  task automatic send_item(logic [2:0] op, logic [5:0] pos, logic [31:0] val);
    mode     <= op;
    position <= pos;
    value    <= val;
    in_valid <= 1'b1;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    predict_list_op(op, pos, val);
    item_count++;
    mode_count[op]++;
    if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_random_item(traffic_bias_t bias);
    int          r;
    logic [2:0]  op;
    logic [5:0]  pos;
    logic [31:0] val;
    r = $urandom_range(0, 99);
    case (bias)
      BIAS_GROW: begin
        if (r < 80)      op = 3'($urandom_range(M_APPEND, M_INSERT));
        else if (r < 88) op = M_DUMP;
        else if (r < 93) op = M_REVERSE;
        else if (r < 97) op = M_REMOVE;
        else             op = 3'($urandom_range(M_SPARE_A, M_SPARE_B));
      end
      BIAS_SHRINK: begin
        if (r < 50)      op = M_REMOVE;
        else if (r < 65) op = 3'($urandom_range(M_APPEND, M_INSERT));
        else if (r < 80) op = M_DUMP;
        else if (r < 90) op = M_REVERSE;
        else             op = 3'($urandom_range(M_SPARE_A, M_SPARE_B));
      end
      default: begin
        if (r < 45)      op = 3'($urandom_range(M_APPEND, M_INSERT));
        else if (r < 65) op = M_REMOVE;
        else if (r < 78) op = M_DUMP;
        else if (r < 88) op = M_REVERSE;
        else if (r < 93) op = 3'($urandom_range(M_SPARE_A, M_SPARE_B));
        else             op = M_INSERT;
      end
    endcase
    if (op == M_INSERT && $urandom_range(0, 99) < 85)
      pos = 6'($urandom_range(0, list_model.size()));
    else
      pos = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 19))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7FFF_FFFF;
      2:       val = 32'h0000_0000;
      3:       val = 32'hFFFF_FFFF;
      default: val = $urandom;
    endcase
    send_item(op, pos, val);
  endtask

  task automatic test_empty_list();
    send_item(M_REMOVE, 6'd0, 32'd0);
    send_item(M_DUMP, 6'd0, 32'd0);
    send_item(M_REVERSE, 6'd0, 32'd0);
    send_item(M_SPARE_A, 6'd63, 32'hFFFF_FFFF);
    send_item(M_SPARE_B, 6'd42, 32'h5555_5555);
    send_item(M_INSERT, 6'd1, 32'h1234_5678);
    send_item(M_INSERT, 6'd63, 32'hAAAA_AAAA);
  endtask

  task automatic test_insert_modes();
    send_item(M_APPEND, 6'd63, 32'h7FFF_FFFF);
    send_item(M_APPEND, 6'd0, 32'h8000_0000);
    send_item(M_HEAD, 6'd21, 32'h0000_0000);
    send_item(M_HEAD, 6'd0, 32'hFFFF_FFFF);
    send_item(M_INSERT, 6'd2, 32'd12345);
    send_item(M_INSERT, 6'd5, -32'sd6789);
    send_item(M_INSERT, 6'd7, 32'd99);
    send_item(M_DUMP, 6'd0, 32'd0);
  endtask

  task automatic test_reverse_and_dump();
    send_item(M_REVERSE, 6'd0, 32'd0);
    send_item(M_DUMP, 6'd0, 32'd0);
    send_item(M_REMOVE, 6'd0, 32'd0);
    send_item(M_REMOVE, 6'd0, 32'd0);
    send_item(M_REVERSE, 6'd0, 32'd0);
    send_item(M_DUMP, 6'd0, 32'd0);
  endtask

  task automatic test_random_traffic();
    int            sent;
    int            seg_len;
    traffic_bias_t bias;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      bias    = traffic_bias_t'($urandom_range(BIAS_GROW, BIAS_MIXED));
      idle_on = ($urandom_range(0, 3) != 0);
      seg_len = $urandom_range(15, 45);
      for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
        send_random_item(bias);
        sent++;
      end
    end
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    for (int i = 0; i < TAIL_ITEMS; i++) send_random_item(BIAS_MIXED);
  endtask

  initial begin
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (idle_on && !quiet) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d element %0d element_valid %0d last %0d",
               status, element, element_valid, last);
        error_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        result_count++;
        if (status !== oldest_result.status) begin
          $error("status mismatch: expected %0d, actual %0d", oldest_result.status, status);
          error_count++;
        end
        if (element !== oldest_result.element) begin
          $error("element mismatch: expected %0d, actual %0d",
                 $signed(oldest_result.element), element);
          error_count++;
        end
        if (element_valid !== oldest_result.element_valid) begin
          $error("element_valid mismatch: expected %0d, actual %0d",
                 oldest_result.element_valid, element_valid);
          error_count++;
        end
        if (last !== oldest_result.last) begin
          $error("last mismatch: expected %0d, actual %0d", oldest_result.last, last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int flush_cycles;
    foreach (mode_count[i]) mode_count[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_insert_modes();
    test_reverse_and_dump();
    test_random_traffic();
    test_quiet_tail();
    in_valid <= 1'b0;
    flush_cycles = 0;
    while (expected_results.size() != 0 && flush_cycles < FLUSH_LIMIT) begin
      @(posedge clk);
      flush_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    $display("Sent %0d items, checked %0d results, hit a full store %0d times.",
             item_count, result_count, full_hits);
    $display("%0d inserts, %0d removals, %0d reversals, %0d dumps, %0d spare modes.",
             mode_count[M_APPEND] + mode_count[M_HEAD] + mode_count[M_INSERT],
             mode_count[M_REMOVE], mode_count[M_REVERSE], mode_count[M_DUMP],
             mode_count[M_SPARE_A] + mode_count[M_SPARE_B]);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
